/* rtl/imabd_pkg.sv */
// Shared types, constants and tables for the IMA ADPCM block decoder.
package imabd_pkg;

    localparam int MAX_CHANNELS_DEF = 2;

    localparam int CODE_W   = 32;
    localparam int NIB_W    = 4;
    localparam int NIB_NUM  = CODE_W / NIB_W;
    localparam int CNT_W    = $clog2(NIB_NUM);
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 7;
    localparam int POS_W    = 5;
    localparam int CC_W     = 2;

    localparam logic [IDX_W-1:0]    IDX_MAX    = 7'd88;
    localparam logic [CC_W-1:0]     CC_MONO    = 2'd1;
    localparam logic [CC_W-1:0]     CC_STEREO  = 2'd2;
    localparam logic [POS_W-1:0]    BLK_MONO   = 5'd9;
    localparam logic [POS_W-1:0]    BLK_STEREO = 5'd18;
    localparam logic signed [17:0]  PRED_MAX   = 18'sd32767;
    localparam logic signed [17:0]  PRED_MIN   = -18'sd32768;

    // Per-channel decoder state: predictor and step index
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pred;
        logic [IDX_W-1:0]           idx;
    } chan_st_t;

    // Standard IMA step sizes
    localparam logic [15:0] STEP_TAB [0:88] = '{
        16'd7,     16'd8,     16'd9,     16'd10,    16'd11,    16'd12,    16'd13,
        16'd14,    16'd16,    16'd17,    16'd19,    16'd21,    16'd23,    16'd25,
        16'd28,    16'd31,    16'd34,    16'd37,    16'd41,    16'd45,    16'd50,
        16'd55,    16'd60,    16'd66,    16'd73,    16'd80,    16'd88,    16'd97,
        16'd107,   16'd118,   16'd130,   16'd143,   16'd157,   16'd173,   16'd190,
        16'd209,   16'd230,   16'd253,   16'd279,   16'd307,   16'd337,   16'd371,
        16'd408,   16'd449,   16'd494,   16'd544,   16'd598,   16'd658,   16'd724,
        16'd796,   16'd876,   16'd963,   16'd1060,  16'd1166,  16'd1282,  16'd1411,
        16'd1552,  16'd1707,  16'd1878,  16'd2066,  16'd2272,  16'd2499,  16'd2749,
        16'd3024,  16'd3327,  16'd3660,  16'd4026,  16'd4428,  16'd4871,  16'd5358,
        16'd5894,  16'd6484,  16'd7132,  16'd7845,  16'd8630,  16'd9493,  16'd10442,
        16'd11487, 16'd12635, 16'd13899, 16'd15289, 16'd16818, 16'd18500, 16'd20350,
        16'd22385, 16'd24623, 16'd27086, 16'd29794, 16'd32767
    };

    // Step index adjustment: -1 for small magnitudes, else 2,4,6,8
    function automatic logic signed [7:0] idx_adj(input logic [NIB_W-1:0] code);
        logic signed [7:0] r;
        if (code[2])
        begin
            r = $signed({5'd0, code[1:0], 1'b0}) + 8'sd2;
        end
        else
        begin
            r = -8'sd1;
        end
        return r;
    endfunction

endpackage

/* rtl/imabd_step.sv */
// One IMA ADPCM nibble decode: predictor and step index update.
module imabd_step (
    input  logic [3:0]           code,
    input  imabd_pkg::chan_st_t  cur,
    output imabd_pkg::chan_st_t  nxt
);
    import imabd_pkg::*;

    logic [IDX_W-1:0]   sp;
    logic [15:0]        step;
    logic [16:0]        delta;
    logic signed [17:0] sum;
    logic signed [7:0]  idx_sum;

    // Step lookup and delta build
    always_comb
    begin
        sp    = (cur.idx > IDX_MAX) ? IDX_MAX : cur.idx;
        step  = STEP_TAB[sp];
        delta = {4'd0, step[15:3]}
              + (code[2] ? {1'b0, step} : 17'd0)
              + (code[1] ? {2'd0, step[15:1]} : 17'd0)
              + (code[0] ? {3'd0, step[15:2]} : 17'd0);
    end

    // Predictor update with saturation
    always_comb
    begin
        sum = {{2{cur.pred[15]}}, cur.pred}
            + (code[3] ? -$signed({1'b0, delta}) : $signed({1'b0, delta}));
        if (sum > PRED_MAX)
        begin
            nxt.pred = 16'sh7fff;
        end
        else if (sum < PRED_MIN)
        begin
            nxt.pred = 16'sh8000;
        end
        else
        begin
            nxt.pred = sum[SAMPLE_W-1:0];
        end
    end

    // Step index update, clamped to the table
    always_comb
    begin
        idx_sum = $signed({1'b0, sp}) + idx_adj(code);
        if (idx_sum < 8'sd0)
        begin
            nxt.idx = '0;
        end
        else if (idx_sum > $signed({1'b0, IDX_MAX}))
        begin
            nxt.idx = IDX_MAX;
        end
        else
        begin
            nxt.idx = idx_sum[IDX_W-1:0];
        end
    end

endmodule

/* rtl/ima_adpcm_block_decoder_top.sv */
// Top level of the IMA ADPCM block decoder: word sequencer, nibble shifter, buffer.
//
//  channel   direction  tdata            tuser         tlast
//  s_axis    in         code_word[31:0]  stream_start  -
//  m_axis    out        sample[15:0]     channel       last
//  cfg       in         channel_count    (write only, cfg_we/cfg_wdata)
//
// A header word is taken while idle. A code word shifts out one nibble a cycle
// through the single decode unit in mono (unless the output stalls) or for a
// stereo left word. A stereo right word sends each buffered left sample, then
// the right sample. The next word is taken only once the current one is done.
// Reset restores mono, block position zero and zeroed channel state.
// A stalled output holds the decoder at its nibble until taken (not on a left word).
module ima_adpcm_block_decoder_top #(
    parameter int MaxChannels = imabd_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,       // channel_count
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // code_word
    input  logic        s_axis_tuser,    // stream_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // sample
    output logic        m_axis_tuser,    // channel
    output logic        m_axis_tlast     // last
);
    import imabd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DEC  = 3'b010,
        ST_BUF  = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        MODE_MONO  = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [CC_W-1:0]    cc_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ch_reg, ch_next;
    chan_st_t           st_reg [MaxChannels];
    logic [CODE_W-1:0]  shift_reg;
    logic [SAMPLE_W-1:0] buf_mem [NIB_NUM];
    logic [SAMPLE_W-1:0] buf_rd_reg;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic               out_ch_reg, out_ch_next;
    logic               out_last_reg, out_last_next;
    logic               out_valid_reg, out_valid_next;

    logic               stereo, in_acc, can_load, dec_adv, buf_adv, out_load;
    logic               is_hdr, hdr_ch;
    logic [POS_W-1:0]   blen, nch, pos_eff, pos_inc;
    chan_st_t           hdr_st, dec_cur, dec_nxt;

    // Nibble decode unit
    assign dec_cur = st_reg[ch_reg];

    imabd_step u_step (
        .code (shift_reg[NIB_W-1:0]),
        .cur  (dec_cur),
        .nxt  (dec_nxt)
    );

    // Block position and word classification
    always_comb
    begin
        stereo  = (cc_reg == CC_STEREO) && (MaxChannels >= 2);
        blen    = stereo ? BLK_STEREO : BLK_MONO;
        nch     = stereo ? 5'd2 : 5'd1;
        pos_eff = (s_axis_tuser || pos_reg >= blen) ? '0 : pos_reg;
        is_hdr  = pos_eff < nch;
        hdr_ch  = stereo && pos_eff[0];
        pos_inc = pos_eff + 5'd1;
        pos_next = (pos_inc >= blen) ? '0 : pos_inc;
    end

    // Header word: predictor and clamped step index
    always_comb
    begin
        hdr_st.pred = s_axis_tdata[15:0];
        if (s_axis_tdata[31])
        begin
            hdr_st.idx = '0;
        end
        else if (s_axis_tdata[30:16] > {8'd0, IDX_MAX})
        begin
            hdr_st.idx = IDX_MAX;
        end
        else
        begin
            hdr_st.idx = s_axis_tdata[22:16];
        end
    end

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign can_load      = !out_valid_reg || m_axis_tready;
    assign dec_adv       = (state_reg == ST_DEC) && (mode_reg == MODE_LEFT || can_load);
    assign buf_adv       = (state_reg == ST_BUF) && can_load;
    assign out_load      = (dec_adv && mode_reg != MODE_LEFT) || buf_adv;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !is_hdr)
                begin
                    cnt_next = '0;
                    if (!stereo)
                    begin
                        mode_next  = MODE_MONO;
                        ch_next    = 1'b0;
                        state_next = ST_DEC;
                    end
                    else if (!pos_eff[0])
                    begin
                        mode_next  = MODE_LEFT;
                        ch_next    = 1'b0;
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        mode_next  = MODE_RIGHT;
                        ch_next    = 1'b1;
                        state_next = ST_BUF;
                    end
                end
            end
            ST_DEC:
            begin
                if (dec_adv)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NIB_NUM - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (mode_reg == MODE_RIGHT)
                    begin
                        state_next = ST_BUF;
                    end
                end
            end
            ST_BUF:
            begin
                if (buf_adv)
                begin
                    state_next = ST_DEC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word selection
    always_comb
    begin
        out_sample_next = out_sample_reg;
        out_ch_next     = out_ch_reg;
        out_last_next   = out_last_reg;
        if (buf_adv)
        begin
            out_sample_next = buf_rd_reg;
            out_ch_next     = 1'b0;
            out_last_next   = 1'b0;
        end
        else if (out_load)
        begin
            out_sample_next = dec_nxt.pred;
            out_ch_next     = ch_reg;
            out_last_next   = (cnt_reg == CNT_W'(NIB_NUM - 1));
        end
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    // Control and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_MONO;
            cc_reg        <= CC_MONO;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MaxChannels; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cc_reg <= cfg_wdata;
            end
            if (in_acc)
            begin
                pos_reg <= pos_next;
            end
            if (in_acc && is_hdr)
            begin
                st_reg[hdr_ch] <= hdr_st;
            end
            else if (dec_adv)
            begin
                st_reg[ch_reg] <= dec_nxt;
            end
        end
    end

    // Nibble shift register and output payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            shift_reg <= s_axis_tdata;
        end
        else if (dec_adv)
        begin
            shift_reg <= {{NIB_W{1'b0}}, shift_reg[CODE_W-1:NIB_W]};
        end
        out_sample_reg <= out_sample_next;
        out_ch_reg     <= out_ch_next;
        out_last_reg   <= out_last_next;
    end

    // Left group buffer: written while decoding a left word, read ahead by count
    always_ff @(posedge clk)
    begin
        if (dec_adv && mode_reg == MODE_LEFT)
        begin
            buf_mem[cnt_reg] <= dec_nxt.pred;
        end
        buf_rd_reg <= buf_mem[cnt_next];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_ch_reg;
    assign m_axis_tlast  = out_last_reg;

    // Step index of channel 0 never leaves the table
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[0].idx <= IDX_MAX)
        else $error("step index out of range");

    // Buffered samples are only replayed for a right word
    a_buf_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUF) |-> (mode_reg == MODE_RIGHT))
        else $error("buffer replay outside right word");

    // Block position stays inside the longest block
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < BLK_STEREO)
        else $error("block position out of range");

    // A buffered sample is always followed by its right-channel partner
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        buf_adv |=> (state_reg == ST_DEC && ch_reg == 1'b1))
        else $error("left replay not followed by right decode");

endmodule
